/* rtl/lifo_stack_with_dedup_core_macros.svh */
// Assertion helpers for the stack core.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef LIFO_STACK_WITH_DEDUP_CORE_MACROS_SVH
`define LIFO_STACK_WITH_DEDUP_CORE_MACROS_SVH

// Same-cycle implication.
`define LSD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsd: same-cycle check failed");

// Next-cycle implication.
`define LSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsd: next-cycle check failed");

`endif

/* rtl/lsd_pkg.sv */
package lsd_pkg;

    // Stack geometry
    localparam int DEPTH = 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Request kinds
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_DEDUP = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] push_value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] pop_value;
        logic [3:0]         fill_count;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_DD_FETCH,
        S_DD_LOAD,
        S_DD_SCAN,
        S_DD_CMP,
        S_DD_NEXT,
        S_RESP
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic       latch_req;
        logic       set_status;
        logic [1:0] status_code;
        logic       push_wr;
        logic       pop_rd;
        logic       pop_capture;
        logic       dd_init;
        logic       dd_fetch;
        logic       dd_load;
        logic       dd_scan_rd;
        logic       dd_keep;
        logic       dd_drop;
        logic       dd_inc_k;
        logic       dd_finish;
        logic       out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       empty;
        logic       k_eq_w;
        logic       match;
        logic       j_done;
        logic       out_free;
    } sts_t;

    // Low four bits of a count, zero-extended when the count is narrower
    function automatic logic [3:0] fill_of(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+3:0] ext;
        ext = {4'b0000, cnt};
        return ext[3:0];
    endfunction

endpackage

/* rtl/lsd_ctrl.sv */
module lsd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  lsd_pkg::sts_t sts,
    output lsd_pkg::cmd_t cmd,
    output logic          idle
);
    import lsd_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        idle       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                if (req_valid)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (sts.kind)
                    KIND_PUSH:
                    begin
                        cmd.set_status = 1'b1;
                        if (sts.full)
                        begin
                            cmd.status_code = STAT_FULL;
                        end
                        else
                        begin
                            cmd.status_code = STAT_DONE;
                            cmd.push_wr     = 1'b1;
                        end
                        state_next = S_RESP;
                    end
                    KIND_POP:
                    begin
                        if (sts.empty)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STAT_EMPTY;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            cmd.pop_rd = 1'b1;
                            state_next = S_POP_WAIT;
                        end
                    end
                    KIND_DEDUP:
                    begin
                        if (sts.empty)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STAT_EMPTY;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            cmd.dd_init = 1'b1;
                            state_next  = S_DD_FETCH;
                        end
                    end
                    default:
                    begin
                        // unused kind: no change, report done
                        cmd.set_status  = 1'b1;
                        cmd.status_code = STAT_DONE;
                        state_next      = S_RESP;
                    end
                endcase
            end
            S_POP_WAIT:
            begin
                cmd.pop_capture = 1'b1;
                state_next      = S_RESP;
            end
            S_DD_FETCH:
            begin
                cmd.dd_fetch = 1'b1;
                state_next   = S_DD_LOAD;
            end
            S_DD_LOAD:
            begin
                cmd.dd_load = 1'b1;
                state_next  = S_DD_SCAN;
            end
            S_DD_SCAN:
            begin
                if (sts.k_eq_w)
                begin
                    cmd.dd_keep = 1'b1;
                    state_next  = S_DD_NEXT;
                end
                else
                begin
                    cmd.dd_scan_rd = 1'b1;
                    state_next     = S_DD_CMP;
                end
            end
            S_DD_CMP:
            begin
                if (sts.match)
                begin
                    cmd.dd_drop = 1'b1;
                    state_next  = S_DD_NEXT;
                end
                else
                begin
                    cmd.dd_inc_k = 1'b1;
                    state_next   = S_DD_SCAN;
                end
            end
            S_DD_NEXT:
            begin
                if (sts.j_done)
                begin
                    cmd.dd_finish = 1'b1;
                    state_next    = S_RESP;
                end
                else
                begin
                    state_next = S_DD_FETCH;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/lsd_dpath.sv */
module lsd_dpath (
    input  logic          clk,
    input  logic          rst_n,
    input  lsd_pkg::req_t req,
    input  lsd_pkg::cmd_t cmd,
    input  logic          rsp_stall,
    output lsd_pkg::sts_t sts,
    output logic          rsp_valid,
    output lsd_pkg::rsp_t rsp
);
    import lsd_pkg::*;

    `include "lifo_stack_with_dedup_core_macros.svh"

    // Stack storage, one write and one registered read per cycle
    logic [31:0] mem [0:DEPTH-1];

    logic [31:0]      rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_data;

    req_t             req_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_dec;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] w_reg;
    logic [31:0]      cur_reg;
    logic [1:0]       status_reg;
    logic [31:0]      pop_reg;
    logic             out_valid_reg;
    rsp_t             out_reg;

    assign count_dec = count_reg - CNT_W'(1);

    // Memory address and data select
    always_comb
    begin
        rd_en   = cmd.pop_rd | cmd.dd_fetch | cmd.dd_scan_rd;
        rd_addr = k_reg[IDX_W-1:0];
        if (cmd.pop_rd)
        begin
            rd_addr = count_dec[IDX_W-1:0];
        end
        else if (cmd.dd_fetch)
        begin
            rd_addr = j_reg[IDX_W-1:0];
        end
        wr_en   = cmd.push_wr | cmd.dd_keep;
        wr_addr = cmd.push_wr ? count_reg[IDX_W-1:0] : w_reg[IDX_W-1:0];
        wr_data = cmd.push_wr ? req_reg.push_value : cur_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Fill count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.push_wr)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop_rd)
        begin
            count_next = count_dec;
        end
        else if (cmd.dd_finish)
        begin
            count_next = w_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Dedup walk: j reads each entry, w is the kept prefix, k scans it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg <= '0;
            k_reg <= '0;
            w_reg <= '0;
        end
        else
        begin
            if (cmd.dd_init)
            begin
                j_reg <= '0;
                w_reg <= '0;
            end
            if (cmd.dd_load)
            begin
                k_reg <= '0;
            end
            if (cmd.dd_inc_k)
            begin
                k_reg <= k_reg + CNT_W'(1);
            end
            if (cmd.dd_keep)
            begin
                w_reg <= w_reg + CNT_W'(1);
                j_reg <= j_reg + CNT_W'(1);
            end
            if (cmd.dd_drop)
            begin
                j_reg <= j_reg + CNT_W'(1);
            end
        end
    end

    // Request, candidate word and result fields
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_reg <= req;
        end
        if (cmd.dd_load)
        begin
            cur_reg <= rd_data_reg;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
            pop_reg    <= '0;
        end
        else if (cmd.pop_capture)
        begin
            status_reg <= STAT_DONE;
            pop_reg    <= rd_data_reg;
        end
        else if (cmd.dd_finish)
        begin
            status_reg <= STAT_DONE;
            pop_reg    <= '0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.status     <= status_reg;
            out_reg.pop_value  <= pop_reg;
            out_reg.fill_count <= fill_of(count_reg);
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Status to controller
    always_comb
    begin
        sts.kind     = req_reg.kind;
        sts.full     = (count_reg >= CNT_W'(DEPTH));
        sts.empty    = (count_reg == '0);
        sts.k_eq_w   = (k_reg == w_reg);
        sts.match    = (rd_data_reg == cur_reg);
        sts.j_done   = (j_reg == count_reg);
        sts.out_free = !out_valid_reg || !rsp_stall;
    end

    `LSD_ASSERT_NEXT(a_push_grows, cmd.push_wr, count_reg == $past(count_reg) + CNT_W'(1))
    `LSD_ASSERT_IMPL(a_keep_behind_read, cmd.dd_keep, w_reg <= j_reg && j_reg < count_reg)
    `LSD_ASSERT_IMPL(a_finish_nonempty, cmd.dd_finish, w_reg != '0 && w_reg <= count_reg)
    `LSD_ASSERT_IMPL(a_load_when_free, cmd.out_load, !out_valid_reg || !rsp_stall)

endmodule

/* rtl/lifo_stack_with_dedup_core.sv */
// Channel  Handshake              Payload
// req      req_valid / req_stall  lsd_pkg::req_t  (kind, push_value)
// rsp      rsp_valid / rsp_stall  lsd_pkg::rsp_t  (status, pop_value, fill_count)
//
// One request at a time. Push, refused requests and the unused kind go through the
// execute and response states before the next acceptance; pop also waits for the
// registered memory read. Dedup walks entries j = 0..n-1 over the one read port,
// comparing each entry with the w distinct values kept below it until one matches.
// rst_n clears the fill count, controller and output valid; entries are not cleared.
// A stalled result holds in the output register; the next request may be accepted
// meanwhile and its result waits until the register frees.
module lifo_stack_with_dedup_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  lsd_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output lsd_pkg::rsp_t rsp
);
    import lsd_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic idle;

    // Requests are taken only while the controller waits for work
    assign req_stall = !idle;

    lsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .sts       (sts),
        .cmd       (cmd),
        .idle      (idle)
    );

    lsd_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
